// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, quiet while reset is held
`define VMDS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define VMDS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VMDS_ASSERT_CLK(lbl, prop, msg)
`define VMDS_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ----- sv/vmds_pkg.sv -----
// types, codes and reset values for the vacuum microwave dryer sequencer
package vmds_pkg;

  // commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  // phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PUMP  = 3'd1;
  localparam logic [2:0] PH_HEAT  = 3'd2;
  localparam logic [2:0] PH_VENT  = 3'd3;
  localparam logic [2:0] PH_ABORT = 3'd4;

  // finish codes
  localparam logic [1:0] FIN_NONE    = 2'd0;
  localparam logic [1:0] FIN_DONE    = 2'd1;
  localparam logic [1:0] FIN_ABORTED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_VACUUM_TH = 2'd0;
  localparam logic [1:0] CFG_VENT_TH   = 2'd1;
  localparam logic [1:0] CFG_HUM_TGT   = 2'd2;
  localparam logic [1:0] CFG_TOG_PER   = 2'd3;

  // register reset values
  localparam logic [7:0] VACUUM_TH_RST = 8'hA8;  // -88 kPa
  localparam logic [7:0] VENT_TH_RST   = 8'hFE;  // -2 kPa
  localparam logic [6:0] HUM_TGT_RST   = 7'd10;
  localparam logic [3:0] TOG_PER_RST   = 4'd5;

  localparam logic [3:0] TOG_CNT_MAX = 4'hF;

  typedef struct packed {
    logic [7:0] vacuum_threshold;
    logic [7:0] vent_threshold;
    logic [6:0] humidity_target;
    logic [3:0] toggle_period;
  } vmds_cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       mag;
    logic [3:0] tog_cnt;
    logic       inlet;
  } vmds_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       keep_running;
    logic [7:0] pressure;
    logic [6:0] humidity;
    logic       tick;
  } vmds_item_t;

  typedef struct packed {
    logic       magnetron_on;
    logic       fan_on;
    logic       inlet_open;
    logic       pump_on;
    logic       connector_open;
    logic [2:0] phase;
    logic [1:0] finished;
  } vmds_res_t;

endpackage

// ----- sv/vmds_step.sv -----
// next-state and actuator logic for one sampled beat
module vmds_step
  import vmds_pkg::*;
(
  input  vmds_cfg_t   cfg,
  input  vmds_state_t st,
  input  vmds_item_t  item,
  output vmds_state_t st_nxt,
  output vmds_res_t   res
);

  logic       below_vac;
  logic       above_vent;
  logic       dry;
  logic [3:0] cnt_inc;
  logic [1:0] fin;

  // threshold compares
  assign below_vac  = $signed(item.pressure) < $signed(cfg.vacuum_threshold);
  assign above_vent = $signed(item.pressure) > $signed(cfg.vent_threshold);
  assign dry        = item.humidity < cfg.humidity_target;

  // saturating tick count while heating
  assign cnt_inc = (item.tick && (st.tog_cnt < TOG_CNT_MAX)) ? st.tog_cnt + 4'd1 : st.tog_cnt;

  // phase sequencing
  always_comb begin
    st_nxt = st;
    fin    = FIN_NONE;
    case (item.cmd)
      CMD_START: begin
        st_nxt.phase   = item.keep_running ? PH_PUMP : PH_ABORT;
        st_nxt.mag     = 1'b0;
        st_nxt.tog_cnt = '0;
        if (item.keep_running) begin
          st_nxt.inlet = 1'b0;
        end
      end
      CMD_RESET: begin
        st_nxt = '{phase: PH_IDLE, mag: 1'b0, tog_cnt: 4'd0, inlet: 1'b0};
      end
      CMD_STEP: begin
        case (st.phase)
          PH_IDLE: begin
          end
          PH_PUMP: begin
            if (!item.keep_running) begin
              st_nxt.phase   = PH_ABORT;
              st_nxt.mag     = 1'b0;
              st_nxt.tog_cnt = '0;
            end else if (below_vac) begin
              st_nxt.phase   = PH_HEAT;
              st_nxt.mag     = 1'b1;
              st_nxt.tog_cnt = '0;
            end
          end
          PH_HEAT: begin
            if (!item.keep_running) begin
              st_nxt.phase   = PH_ABORT;
              st_nxt.mag     = 1'b0;
              st_nxt.tog_cnt = '0;
            end else if (dry) begin
              st_nxt.phase   = PH_VENT;
              st_nxt.mag     = 1'b0;
              st_nxt.tog_cnt = '0;
            end else if (cnt_inc >= cfg.toggle_period) begin
              st_nxt.mag     = ~st.mag;
              st_nxt.tog_cnt = '0;
            end else begin
              st_nxt.tog_cnt = cnt_inc;
            end
          end
          PH_VENT: begin
            if (!item.keep_running) begin
              st_nxt.phase   = PH_ABORT;
              st_nxt.mag     = 1'b0;
              st_nxt.tog_cnt = '0;
            end else if (above_vent) begin
              st_nxt = '{phase: PH_IDLE, mag: 1'b0, tog_cnt: 4'd0, inlet: 1'b0};
              fin    = FIN_DONE;
            end else begin
              st_nxt.inlet = 1'b1;
            end
          end
          PH_ABORT: begin
            if (above_vent) begin
              st_nxt = '{phase: PH_IDLE, mag: 1'b0, tog_cnt: 4'd0, inlet: 1'b0};
              fin    = FIN_ABORTED;
            end else begin
              st_nxt.inlet = 1'b1;
            end
          end
          default: begin
            st_nxt = '{phase: PH_IDLE, mag: 1'b0, tog_cnt: 4'd0, inlet: 1'b0};
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // actuator decode from the new phase
  always_comb begin
    res                = '0;
    res.phase          = st_nxt.phase;
    res.finished       = fin;
    res.inlet_open     = (st_nxt.phase != PH_IDLE) && st_nxt.inlet;
    res.pump_on        = (st_nxt.phase == PH_PUMP) || (st_nxt.phase == PH_HEAT);
    res.fan_on         = (st_nxt.phase == PH_HEAT);
    res.magnetron_on   = (st_nxt.phase == PH_HEAT) && st_nxt.mag;
    res.connector_open = (st_nxt.phase inside {PH_PUMP, PH_HEAT, PH_VENT, PH_ABORT});
  end

endmodule

// ----- sv/vmds_skid.sv -----
// result register with a skid slot so a stalled sink does not block the input until the skid slot is full
module vmds_skid
  import vmds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  vmds_res_t push_data,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_ready,
  output vmds_res_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  vmds_res_t out_data_r, out_data_nxt;
  vmds_res_t skid_data_r, skid_data_nxt;
  logic      pop;

  assign pop       = out_valid_r && out_ready;
  assign ready     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // fill and drain of the two slots
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload flops
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// ----- sv/vacuum_microwave_dry_sequencer.sv -----
// top level of the vacuum microwave dryer sequencer
//
//  channel | direction | tuser        | tdata / data
//  in_     | sink      | cmd          | keep_running, pressure, humidity, tick
//  out_    | source    | -            | actuators, phase, finished
//  cfg_    | sink      | -            | register index cfg_addr, value cfg_wdata
//
// one beat per cycle while in_tready is high: the sequencer state updates in the accepting cycle and
// the result is registered into the output slot, or into the skid slot if out_ is stalled.
// throughput is set by the two-slot result buffer: input is taken whenever
// the skid slot is empty, so a sink stall costs one extra beat before in_tready drops.
// rst_n is synchronous: phase idle, actuators off, registers to defaults.
`include "assert_macros.svh"

module vacuum_microwave_dry_sequencer
  import vmds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [23:0] in_tdata,   // [0] keep_running, [8:1] pressure, [15:9] humidity,
                                  // [16] tick, [23:17] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] magnetron_on, [1] fan_on, [2] inlet_open,
                                  // [3] pump_on, [4] connector_open, [7:5] phase,
                                  // [9:8] finished, [15:10] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  vmds_cfg_t   cfg_r;
  vmds_state_t st_r;
  vmds_state_t st_nxt;
  vmds_item_t  item;
  vmds_res_t   res;
  vmds_res_t   out_res;
  logic        accept;

  // unpack the input beat
  assign item.cmd          = in_tuser;
  assign item.keep_running = in_tdata[0];
  assign item.pressure     = in_tdata[8:1];
  assign item.humidity     = in_tdata[15:9];
  assign item.tick         = in_tdata[16];

  assign accept = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vacuum_threshold <= VACUUM_TH_RST;
      cfg_r.vent_threshold   <= VENT_TH_RST;
      cfg_r.humidity_target  <= HUM_TGT_RST;
      cfg_r.toggle_period    <= TOG_PER_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VACUUM_TH: cfg_r.vacuum_threshold <= cfg_wdata;
        CFG_VENT_TH:   cfg_r.vent_threshold   <= cfg_wdata;
        CFG_HUM_TGT:   cfg_r.humidity_target  <= cfg_wdata[6:0];
        CFG_TOG_PER:   cfg_r.toggle_period    <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, mag: 1'b0, tog_cnt: 4'd0, inlet: 1'b0};
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  vmds_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item),
    .st_nxt (st_nxt),
    .res    (res)
  );

  vmds_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // pack the result beat
  assign out_tdata = {6'd0, out_res.finished, out_res.phase, out_res.connector_open,
                      out_res.pump_on, out_res.inlet_open, out_res.fan_on,
                      out_res.magnetron_on};

  // checks
  `VMDS_ASSERT_CLK(a_stall_has_result, !in_tready |-> out_tvalid,
                   "input stalled with no result waiting")
  `VMDS_ASSERT_CLK(a_finish_is_idle, out_tvalid && (out_res.finished != FIN_NONE) |->
                   out_res.phase == PH_IDLE, "finish reported outside idle")
  `VMDS_ASSERT_CLK(a_mag_only_heat, out_tvalid && out_res.magnetron_on |->
                   out_res.phase == PH_HEAT, "magnetron on outside heating")
  `VMDS_ASSERT_CLK(a_reset_cmd_idle, accept && (item.cmd == CMD_RESET) |=>
                   st_r.phase == PH_IDLE, "reset command did not return to idle")
  `VMDS_ASSERT_RST(a_rst_idle, !rst_n |=> (st_r.phase == PH_IDLE) && !out_tvalid,
                   "state not cleared by reset")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the vacuum microwave dryer sequencer
module testbench
  import vmds_pkg::*;
();

  localparam int         IDLE_LIMIT       = 4000;
  localparam int         BEATS_PER_SETTING = 250;
  localparam int         SETTING_COUNT    = 8;
  localparam int         RUN_STEP_LIMIT   = 160;
  localparam logic [1:0] CMD_UNUSED       = 2'd3;

  // dryer sequencer predictor plus the queue of outputs it still owes
  class dryer_scoreboard;
    logic signed [7:0] vac_th;
    logic signed [7:0] vent_th;
    logic [6:0]        hum_tgt;
    logic [3:0]        tog_per;
    logic [2:0]        phase;
    logic              mag;
    logic [3:0]        tog_cnt;
    logic              inlet;
    vmds_res_t         owed_outputs[$];
    int unsigned       errors;

    function new();
      vac_th  = VACUUM_TH_RST;
      vent_th = VENT_TH_RST;
      hum_tgt = HUM_TGT_RST;
      tog_per = TOG_PER_RST;
      errors  = 0;
      enter_idle();
    endfunction

    function void enter_idle();
      phase   = PH_IDLE;
      mag     = 1'b0;
      tog_cnt = '0;
      inlet   = 1'b0;
    endfunction

    // abort keeps the inlet as it was
    function void enter_abort();
      phase   = PH_ABORT;
      mag     = 1'b0;
      tog_cnt = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_VACUUM_TH: vac_th  = val;
        CFG_VENT_TH:   vent_th = val;
        CFG_HUM_TGT:   hum_tgt = val[6:0];
        CFG_TOG_PER:   tog_per = val[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_outputs.size();
    endfunction

    // advance the sequence by one accepted beat and queue the outputs it causes
    function void note_item(vmds_item_t it);
      vmds_res_t         r;
      logic signed [7:0] pres;
      pres = it.pressure;
      r = '0;
      case (it.cmd)
        CMD_START: begin
          if (!it.keep_running) enter_abort();
          else begin
            phase   = PH_PUMP;
            mag     = 1'b0;
            tog_cnt = '0;
            inlet   = 1'b0;
          end
        end
        CMD_RESET: enter_idle();
        CMD_STEP: begin
          case (phase)
            PH_IDLE: ;
            PH_PUMP: begin
              if (!it.keep_running) enter_abort();
              else if (pres < vac_th) begin
                phase   = PH_HEAT;
                mag     = 1'b1;
                tog_cnt = '0;
              end
            end
            PH_HEAT: begin
              if (!it.keep_running) enter_abort();
              else if (it.humidity < hum_tgt) begin
                phase   = PH_VENT;
                mag     = 1'b0;
                tog_cnt = '0;
              end else begin
                // tick counter saturates, magnetron flips once the period is reached
                if (it.tick && tog_cnt != TOG_CNT_MAX) tog_cnt = tog_cnt + 4'd1;
                if (tog_cnt >= tog_per) begin
                  mag     = ~mag;
                  tog_cnt = '0;
                end
              end
            end
            PH_VENT: begin
              if (!it.keep_running) enter_abort();
              else if (pres > vent_th) begin
                enter_idle();
                r.finished = FIN_DONE;
              end else inlet = 1'b1;
            end
            PH_ABORT: begin
              if (pres > vent_th) begin
                enter_idle();
                r.finished = FIN_ABORTED;
              end else inlet = 1'b1;
            end
            default: enter_idle();
          endcase
        end
        default: ;
      endcase

      // actuator drives follow the phase after the update
      case (phase)
        PH_PUMP: begin
          r.pump_on        = 1'b1;
          r.connector_open = 1'b1;
        end
        PH_HEAT: begin
          r.magnetron_on   = mag;
          r.fan_on         = 1'b1;
          r.pump_on        = 1'b1;
          r.connector_open = 1'b1;
        end
        PH_VENT, PH_ABORT: r.connector_open = 1'b1;
        default: ;
      endcase
      r.inlet_open = (phase != PH_IDLE) && inlet;
      r.phase      = phase;
      owed_outputs.push_back(r);
    endfunction

    function void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(vmds_res_t got);
      vmds_res_t want;
      if (owed_outputs.size() == 0) begin
        $error("result beat with no expected outputs waiting");
        errors++;
        return;
      end
      want = owed_outputs.pop_front();
      compare_field("magnetron_on", 3'(want.magnetron_on), 3'(got.magnetron_on));
      compare_field("fan_on", 3'(want.fan_on), 3'(got.fan_on));
      compare_field("inlet_open", 3'(want.inlet_open), 3'(got.inlet_open));
      compare_field("pump_on", 3'(want.pump_on), 3'(got.pump_on));
      compare_field("connector_open", 3'(want.connector_open), 3'(got.connector_open));
      compare_field("phase", want.phase, got.phase);
      compare_field("finished", 3'(want.finished), 3'(got.finished));
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser  = '0;
  logic [23:0] in_tdata  = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = '0;
  logic [7:0]  cfg_wdata = '0;

  dryer_scoreboard sb = new();
  vmds_cfg_t       cur_cfg;
  int              burst_left  = 0;
  int              items_sent  = 0;
  int              idle_cycles = 0;
  int              stall_left  = 0;
  int              stall_mode  = 0;
  logic [2:0]      rx_count    = '0;

  vacuum_microwave_dry_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 125 MHz clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern, switching to a randomly chosen mode whenever its hold count runs out
  always @(posedge clk) begin
    rx_count <= rx_count + 3'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= (rx_count != 3'd5);
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // beat monitor: input beats feed the predictor, result beats are checked
  always @(posedge clk) begin : monitor
    vmds_item_t seen_in;
    vmds_res_t  seen_out;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_in.cmd          = in_tuser;
        seen_in.keep_running = in_tdata[0];
        seen_in.pressure     = in_tdata[8:1];
        seen_in.humidity     = in_tdata[15:9];
        seen_in.tick         = in_tdata[16];
        sb.note_item(seen_in);
      end
      if (out_tvalid && out_tready) begin
        seen_out.magnetron_on   = out_tdata[0];
        seen_out.fan_on         = out_tdata[1];
        seen_out.inlet_open     = out_tdata[2];
        seen_out.pump_on        = out_tdata[3];
        seen_out.connector_open = out_tdata[4];
        seen_out.phase          = out_tdata[7:5];
        seen_out.finished       = out_tdata[9:8];
        sb.check_result(seen_out);
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic vmds_item_t make_item(logic [1:0] cmd, logic keep, int pres, int hum,
                                           logic tick);
    vmds_item_t it;
    it.cmd          = cmd;
    it.keep_running = keep;
    it.pressure     = pres[7:0];
    it.humidity     = hum[6:0];
    it.tick         = tick;
    return it;
  endfunction

  // send one beat; the sender works in bursts with random gaps between them
  task automatic push_beat(input vmds_item_t it);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {7'd0, it.tick, it.humidity, it.pressure, it.keep_running};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input vmds_cfg_t c);
    logic [1:0] addrs[4];
    logic [7:0] vals[4];
    addrs = '{CFG_VACUUM_TH, CFG_VENT_TH, CFG_HUM_TGT, CFG_TOG_PER};
    vals  = '{c.vacuum_threshold, c.vent_threshold, {1'b0, c.humidity_target},
              {4'd0, c.toggle_period}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(addrs[i], vals[i]);
    end
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // one drying cycle with plausible sensor trends, plus stops, resets and noise
  task automatic drying_run();
    logic [2:0] stage;
    int         pres;
    int         hum;
    int         steps;
    int         roll;
    logic       keep;
    vmds_item_t it;
    pres = int'($urandom_range(0, 50)) - 10;
    hum  = $urandom_range(20, 127);
    keep = ($urandom_range(0, 15) != 0);
    push_beat(make_item(CMD_START, keep, pres, hum, 1'($urandom_range(0, 1))));
    stage = keep ? PH_PUMP : PH_ABORT;
    steps = 0;
    while (stage != PH_IDLE && steps < RUN_STEP_LIMIT) begin
      steps++;
      case (stage)
        PH_PUMP: pres = pres - int'($urandom_range(0, 12));
        PH_HEAT: hum  = hum - int'($urandom_range(0, 3));
        default: pres = pres + int'($urandom_range(0, 12));
      endcase
      if (pres < -128) pres = -128;
      if (pres > 127) pres = 127;
      if (hum < 0) hum = 0;
      it = make_item(CMD_STEP, 1'b1, pres, hum, 1'($urandom_range(0, 1)));
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        // user stop
        it.keep_running = 1'b0;
        stage = PH_ABORT;
      end else if (roll < 3) begin
        it.cmd = CMD_RESET;
        stage  = PH_IDLE;
      end else if (roll < 4) begin
        it.cmd = CMD_UNUSED;
      end else if (roll < 5) begin
        it.cmd = CMD_START;
        stage  = PH_PUMP;
      end else if (roll < 8) begin
        it = make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 255), $urandom_range(0, 127),
                       1'($urandom_range(0, 1)));
      end else begin
        case (stage)
          PH_PUMP: if (pres < $signed(cur_cfg.vacuum_threshold)) stage = PH_HEAT;
          PH_HEAT: if (hum < cur_cfg.humidity_target) stage = PH_VENT;
          PH_VENT: if (pres > $signed(cur_cfg.vent_threshold)) stage = PH_IDLE;
          default: begin
            // abort vent ignores the stop flag
            it.keep_running = 1'($urandom_range(0, 1));
            if (pres > $signed(cur_cfg.vent_threshold)) stage = PH_IDLE;
          end
        endcase
      end
      push_beat(it);
    end
  endtask

  // main sequence
  initial begin
    vmds_cfg_t settings[SETTING_COUNT];
    int        goal;
    int        tmp;
    cur_cfg = '{VACUUM_TH_RST, VENT_TH_RST, HUM_TGT_RST, TOG_PER_RST};
    settings[0] = '{VACUUM_TH_RST, VENT_TH_RST, HUM_TGT_RST, TOG_PER_RST};
    settings[1] = '{8'h80, 8'h7F, 7'd0, 4'd0};
    settings[2] = '{8'h7F, 8'h80, 7'd127, 4'd15};
    settings[3] = '{8'hEC, 8'h0A, 7'd30, 4'd1};
    settings[4] = '{8'hC4, 8'h00, 7'd100, 4'd15};
    for (int s = 5; s < SETTING_COUNT; s++) begin
      tmp = int'($urandom_range(0, 160)) - 120;
      settings[s].vacuum_threshold = tmp[7:0];
      tmp = int'($urandom_range(0, 90)) - 30;
      settings[s].vent_threshold  = tmp[7:0];
      settings[s].humidity_target = 7'($urandom_range(0, 127));
      settings[s].toggle_period   = 4'($urandom_range(0, 15));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle handling, stop priority, abort vent, toggling, restarts, full cycle
    push_beat(make_item(CMD_STEP, 1'b1, 0, 50, 1'b1));
    push_beat(make_item(CMD_UNUSED, 1'b1, 127, 127, 1'b1));
    push_beat(make_item(CMD_START, 1'b0, 0, 0, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b0, -128, 0, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b0, 127, 0, 1'b0));
    push_beat(make_item(CMD_START, 1'b1, 0, 60, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b1, 0, 60, 1'b1));
    push_beat(make_item(CMD_STEP, 1'b0, -128, 60, 1'b0));
    push_beat(make_item(CMD_START, 1'b1, 0, 60, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b1, -128, 127, 1'b0));
    for (int i = 0; i < 6; i++) push_beat(make_item(CMD_STEP, 1'b1, -100, 100, 1'b1));
    push_beat(make_item(CMD_UNUSED, 1'b0, -100, 100, 1'b1));
    push_beat(make_item(CMD_STEP, 1'b0, -100, 0, 1'b0));
    push_beat(make_item(CMD_START, 1'b1, 0, 80, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b1, -128, 80, 1'b0));
    push_beat(make_item(CMD_START, 1'b1, 0, 80, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b1, -100, 80, 1'b1));
    push_beat(make_item(CMD_STEP, 1'b1, -100, 0, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b1, -128, 0, 1'b0));
    push_beat(make_item(CMD_STEP, 1'b1, 127, 0, 1'b0));
    push_beat(make_item(CMD_START, 1'b1, 10, 40, 1'b1));
    push_beat(make_item(CMD_RESET, 1'b1, 10, 40, 1'b1));

    // random drying runs under each register setting
    for (int s = 0; s < SETTING_COUNT; s++) begin
      drain_results();
      program_regs(settings[s]);
      goal = items_sent + BEATS_PER_SETTING;
      while (items_sent < goal) drying_run();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/vmds_pkg.sv
sv/vmds_step.sv
sv/vmds_skid.sv
sv/vacuum_microwave_dry_sequencer.sv
sim/testbench.sv
